// File: rtl/core/okvt_pkg.sv
// Shared constants, request and status codes, and control types for the key/value table.
`default_nettype none
package okvt_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned POS_W     = 5;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned STS_W     = 2;

  localparam int unsigned IN_BITS   = KEY_W + VAL_W + POS_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = STS_W + IDX_W + KEY_W + VAL_W + CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FINDK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FINDV  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_WRKEY  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_WRVAL  = 3'd6;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic load;
    logic match;
    logic exec;
  } okvt_cmd_t;

  typedef struct packed {
    logic in_find;
  } okvt_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/okvt_ctrl.sv
// Request sequencer and output valid flag for the key/value table.
`default_nettype none
module okvt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire okvt_pkg::okvt_sts_t sts_i,
  output okvt_pkg::okvt_cmd_t     cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       oval_q, oval_d;
  logic       out_free;

  assign out_free    = !oval_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;

  always_comb begin
    state_d = state_q;
    oval_d  = oval_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_find ? S_MATCH : S_EXEC;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          oval_d     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/okvt_dpath.sv
// Entry cells, per-cell match, shift logic and result register of the key/value table.
`default_nettype none
module okvt_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire okvt_pkg::okvt_cmd_t               cmd_i,
  output okvt_pkg::okvt_sts_t                    sts_o,
  input  wire logic [okvt_pkg::REQ_W-1:0]        req_i,
  input  wire logic [okvt_pkg::KEY_W-1:0]        key_i,
  input  wire logic [okvt_pkg::VAL_W-1:0]        val_i,
  input  wire logic [okvt_pkg::POS_W-1:0]        pos_i,
  output logic [okvt_pkg::STS_W-1:0]             res_status_o,
  output logic [okvt_pkg::IDX_W-1:0]             res_index_o,
  output logic [okvt_pkg::KEY_W-1:0]             res_key_o,
  output logic [okvt_pkg::VAL_W-1:0]             res_val_o,
  output logic [okvt_pkg::CNT_W-1:0]             res_count_o
);

  localparam int unsigned D = okvt_pkg::DEPTH;

  logic [okvt_pkg::KEY_W-1:0] key_cell_q [D];
  logic [okvt_pkg::KEY_W-1:0] key_cell_d [D];
  logic [okvt_pkg::VAL_W-1:0] val_cell_q [D];
  logic [okvt_pkg::VAL_W-1:0] val_cell_d [D];
  logic [okvt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [D-1:0]               match_q;

  logic [okvt_pkg::REQ_W-1:0] req_q;
  logic [okvt_pkg::KEY_W-1:0] key_q;
  logic [okvt_pkg::VAL_W-1:0] val_q;
  logic [okvt_pkg::POS_W-1:0] pos_q;

  logic [okvt_pkg::STS_W-1:0] status_d;
  logic [okvt_pkg::IDX_W-1:0] index_d;
  logic [okvt_pkg::KEY_W-1:0] rkey_d;
  logic [okvt_pkg::VAL_W-1:0] rval_d;

  logic [okvt_pkg::IDX_W-1:0] hit_idx;
  logic [okvt_pkg::IDX_W-1:0] rd_addr;
  logic [okvt_pkg::KEY_W-1:0] rd_key;
  logic [okvt_pkg::VAL_W-1:0] rd_val;
  logic                       is_find, full, pos_le_cnt, pos_lt_cnt;
  logic                       app_ok, ins_ok, wk_ok, wv_ok;

  assign sts_o.in_find = (req_i == okvt_pkg::REQ_FINDK) || (req_i == okvt_pkg::REQ_FINDV);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      key_q <= key_i;
      val_q <= val_i;
      pos_q <= pos_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      if (cmd_i.match) begin
        match_q[i] <= (okvt_pkg::CNT_W'(i) < cnt_q) &&
                      ((req_q == okvt_pkg::REQ_FINDK) ? (key_cell_q[i] == key_q)
                                                     : (val_cell_q[i] == val_q));
      end
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = okvt_pkg::IDX_W'(i);
    end
  end

  assign is_find    = (req_q == okvt_pkg::REQ_FINDK) || (req_q == okvt_pkg::REQ_FINDV);
  assign full       = (cnt_q == okvt_pkg::CNT_W'(D));
  assign pos_le_cnt = (okvt_pkg::CNT_W'(pos_q) <= cnt_q);
  assign pos_lt_cnt = (okvt_pkg::CNT_W'(pos_q) < cnt_q);
  assign rd_addr    = is_find ? hit_idx : pos_q[okvt_pkg::IDX_W-1:0];
  assign rd_key     = key_cell_q[rd_addr];
  assign rd_val     = val_cell_q[rd_addr];
  assign app_ok     = (req_q == okvt_pkg::REQ_APPEND) && !full;
  assign ins_ok     = (req_q == okvt_pkg::REQ_INSERT) && pos_le_cnt && !full;
  assign wk_ok      = (req_q == okvt_pkg::REQ_WRKEY) && pos_lt_cnt;
  assign wv_ok      = (req_q == okvt_pkg::REQ_WRVAL) && pos_lt_cnt;

  always_comb begin
    status_d = okvt_pkg::ST_OK;
    index_d  = '0;
    rkey_d   = '0;
    rval_d   = '0;
    unique case (req_q)
      okvt_pkg::REQ_APPEND: begin
        if (full) status_d = okvt_pkg::ST_FULL;
      end
      okvt_pkg::REQ_INSERT: begin
        priority if (!pos_le_cnt) status_d = okvt_pkg::ST_RANGE;
        else if (full) status_d = okvt_pkg::ST_FULL;
        else status_d = okvt_pkg::ST_OK;
      end
      okvt_pkg::REQ_FINDK, okvt_pkg::REQ_FINDV: begin
        if (|match_q) begin
          index_d = hit_idx;
          rkey_d  = rd_key;
          rval_d  = rd_val;
        end else begin
          status_d = okvt_pkg::ST_MISS;
        end
      end
      okvt_pkg::REQ_READ, okvt_pkg::REQ_WRKEY, okvt_pkg::REQ_WRVAL: begin
        if (!pos_lt_cnt) begin
          status_d = okvt_pkg::ST_RANGE;
        end else begin
          rkey_d = (req_q == okvt_pkg::REQ_WRKEY) ? key_q : rd_key;
          rval_d = (req_q == okvt_pkg::REQ_WRVAL) ? val_q : rd_val;
        end
      end
      default: begin
        status_d = okvt_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.exec && (app_ok || ins_ok)) cnt_d = cnt_q + okvt_pkg::CNT_W'(1);
    for (int i = 0; i < D; i++) begin
      key_cell_d[i] = key_cell_q[i];
      val_cell_d[i] = val_cell_q[i];
      if (cmd_i.exec) begin
        if ((app_ok && (okvt_pkg::CNT_W'(i) == cnt_q)) ||
            (ins_ok && (okvt_pkg::POS_W'(i) == pos_q))) begin
          key_cell_d[i] = key_q;
          val_cell_d[i] = val_q;
        end else if (ins_ok && (okvt_pkg::POS_W'(i) > pos_q) && (i > 0)) begin
          key_cell_d[i] = key_cell_q[(i > 0) ? i - 1 : 0];
          val_cell_d[i] = val_cell_q[(i > 0) ? i - 1 : 0];
        end else if (wk_ok && (okvt_pkg::POS_W'(i) == pos_q)) begin
          key_cell_d[i] = key_q;
        end else if (wv_ok && (okvt_pkg::POS_W'(i) == pos_q)) begin
          val_cell_d[i] = val_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      key_cell_q[i] <= key_cell_d[i];
      val_cell_q[i] <= val_cell_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_o <= status_d;
      res_index_o  <= index_d;
      res_key_o    <= rkey_d;
      res_val_o    <= rval_d;
      res_count_o  <= cnt_d;
    end
  end

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + okvt_pkg::CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= okvt_pkg::CNT_W'(D))
    else $error("entry count above depth");

  a_cnt_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> (cnt_q == $past(cnt_q)))
    else $error("entry count changed outside execute");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.exec) && (res_status_o == okvt_pkg::ST_RANGE ||
                          res_status_o == okvt_pkg::ST_FULL ||
                          res_status_o == okvt_pkg::ST_MISS)
    |-> (res_index_o == '0) && (res_key_o == '0) && (res_val_o == '0))
    else $error("error result carries payload");

endmodule
`default_nettype wire

// File: rtl/core/ordered_key_value_table_core.sv
// Top level of the ordered key/value table: stream ports, sequencer and datapath.
//
//  channel  dir  fields
//  s_axis   in   tuser: req_type; tdata: key_in, value_in, position
//  m_axis   out  tdata: status, found_index, key_out, value_out, entry_count
//
// A find steps through load, cell compare and execute; other requests through load
// and execute, and the result register is loaded at execute. One item is in flight
// at a time.
// Reset clears the entry count and the sequencer; entry cells are not cleared.
// A stalled result stays in the output register; execute waits until it is taken.
`default_nettype none
module ordered_key_value_table_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] key_in, [63:32] value_in, [68:64] position, rest zero
  input  wire logic [okvt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [2:0] req_type
  input  wire logic [okvt_pkg::REQ_W-1:0]        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] status, [5:2] found_index, [37:6] key_out, [69:38] value_out,
  // [74:70] entry_count, rest zero
  output logic [okvt_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  localparam int unsigned KO = 0;
  localparam int unsigned VO = okvt_pkg::KEY_W;
  localparam int unsigned PO = okvt_pkg::KEY_W + okvt_pkg::VAL_W;

  okvt_pkg::okvt_cmd_t cmd;
  okvt_pkg::okvt_sts_t sts;

  logic [okvt_pkg::STS_W-1:0] res_status;
  logic [okvt_pkg::IDX_W-1:0] res_index;
  logic [okvt_pkg::KEY_W-1:0] res_key;
  logic [okvt_pkg::VAL_W-1:0] res_val;
  logic [okvt_pkg::CNT_W-1:0] res_count;

  okvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  okvt_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_i        (s_axis_tuser),
    .key_i        (s_axis_tdata[KO +: okvt_pkg::KEY_W]),
    .val_i        (s_axis_tdata[VO +: okvt_pkg::VAL_W]),
    .pos_i        (s_axis_tdata[PO +: okvt_pkg::POS_W]),
    .res_status_o (res_status),
    .res_index_o  (res_index),
    .res_key_o    (res_key),
    .res_val_o    (res_val),
    .res_count_o  (res_count)
  );

  assign m_axis_tdata = {{(okvt_pkg::OUT_DATA_W - okvt_pkg::OUT_BITS){1'b0}},
                         res_count, res_val, res_key, res_index, res_status};

endmodule
`default_nettype wire

// File: sim/ordered_key_value_table_core_checker.sv
// Checker for the key/value table: predicts each reply and compares it with the output item.
module ordered_key_value_table_core_checker
  import okvt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // [31:0] key_in, [63:32] value_in, [68:64] position, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [REQ_W-1:0]      s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [5:2] found_index, [37:6] key_out, [69:38] value_out,
  // [74:70] entry_count, rest zero
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  // status sits in the lowest bits of tdata, so it is the last member here
  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [VAL_W-1:0] value_out;
    logic [KEY_W-1:0] key_out;
    logic [IDX_W-1:0] found_index;
    logic [STS_W-1:0] status;
  } table_reply_t;

  logic [KEY_W-1:0] key_shadow [DEPTH];
  logic [VAL_W-1:0] value_shadow [DEPTH];
  int unsigned      stored = 0;
  table_reply_t     reply_queue [$];

  initial begin
    mismatch_count_o = 0;
    pending_o = 0;
  end

  function automatic table_reply_t predict_reply(input logic [REQ_W-1:0] req,
      input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value,
      input logic [POS_W-1:0] pos);
    table_reply_t r;
    bit           hit;
    r = '0;
    hit = 1'b0;
    case (req)
      REQ_APPEND: begin
        if (stored >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key_shadow[stored] = key;
          value_shadow[stored] = value;
          stored++;
        end
      end
      REQ_INSERT: begin
        if (pos > stored) begin
          r.status = ST_RANGE;
        end else if (stored >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned i = stored; i > pos; i--) begin
            key_shadow[i] = key_shadow[i-1];
            value_shadow[i] = value_shadow[i-1];
          end
          key_shadow[pos] = key;
          value_shadow[pos] = value;
          stored++;
        end
      end
      REQ_FINDK, REQ_FINDV: begin
        r.status = ST_MISS;
        for (int unsigned i = 0; i < stored && !hit; i++) begin
          if ((req == REQ_FINDK) ? (key_shadow[i] == key) : (value_shadow[i] == value)) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_index = IDX_W'(i);
            r.key_out = key_shadow[i];
            r.value_out = value_shadow[i];
          end
        end
      end
      REQ_READ, REQ_WRKEY, REQ_WRVAL: begin
        if (pos >= stored) begin
          r.status = ST_RANGE;
        end else begin
          if (req == REQ_WRKEY) key_shadow[pos] = key;
          if (req == REQ_WRVAL) value_shadow[pos] = value;
          r.key_out = key_shadow[pos];
          r.value_out = value_shadow[pos];
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(stored);
    return r;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
      input logic [31:0] got);
    mismatch_count_o++;
    $display("%0t: %s mismatch: expected 'h%0h, got 'h%0h", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored = 0;
      reply_queue.delete();
    end else begin
      table_reply_t want;
      table_reply_t got;
      if (s_axis_tvalid && s_axis_tready) begin
        reply_queue.push_back(predict_reply(s_axis_tuser, s_axis_tdata[KEY_W-1:0],
            s_axis_tdata[KEY_W +: VAL_W], s_axis_tdata[KEY_W+VAL_W +: POS_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = table_reply_t'(m_axis_tdata[OUT_BITS-1:0]);
        if (reply_queue.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected item: expected none, got 'h%0h", $time, m_axis_tdata);
        end else begin
          want = reply_queue.pop_front();
          if (got.status !== want.status)
            report_field("status", 32'(want.status), 32'(got.status));
          if (got.found_index !== want.found_index)
            report_field("found_index", 32'(want.found_index), 32'(got.found_index));
          if (got.key_out !== want.key_out) report_field("key_out", want.key_out, got.key_out);
          if (got.value_out !== want.value_out)
            report_field("value_out", want.value_out, got.value_out);
          if (got.entry_count !== want.entry_count)
            report_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        end
      end
    end
    pending_o = reply_queue.size();
  end

endmodule

// File: sim/ordered_key_value_table_core_test.sv
// Testbench top for the key/value table: clock, reset, request stimulus and verdict.
module ordered_key_value_table_core_test;
  import okvt_pkg::*;

  localparam logic [REQ_W-1:0] REQ_NOP = 3'd7;
  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned MIXED_ITEMS = 1720;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    mismatch_count;
  int                    pending_count;
  bit                    steady = 1'b0;
  int unsigned           fill_level = 0;

  logic [KEY_W-1:0] key_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
                                     32'h8000_0001, 32'h0000_0001, 32'h5A5A_A5A5};
  logic [VAL_W-1:0] value_pool [6] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h9ABC_DEF0,
                                       32'h0BAD_F00D, 32'h7FFF_FFFE, 32'h0000_0001};

  always #5 clk_i = ~clk_i;

  ordered_key_value_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ordered_key_value_table_core_checker table_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
      input logic [VAL_W-1:0] value, input logic [POS_W-1:0] pos);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[KEY_W-1:0] = key;
    word[KEY_W +: VAL_W] = value;
    word[KEY_W+VAL_W +: POS_W] = pos;
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return key_pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return value_pool[$urandom_range(0, 5)];
  endfunction

  // mostly valid entry indexes, sometimes past the end of the table
  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 99) < 15) return POS_W'($urandom_range(DEPTH, 31));
    return POS_W'($urandom_range(0, DEPTH - 1));
  endfunction

  task automatic run_directed();
    // empty table: misses, bad indexes, unknown request
    send_request(REQ_FINDK, 32'h0000_0000, 32'h0000_0000, 5'd0);
    send_request(REQ_FINDV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
    send_request(REQ_READ, 32'h0000_0000, 32'h0000_0000, 5'd0);
    send_request(REQ_INSERT, 32'h0000_0001, 32'h0000_0001, 5'd1);
    send_request(REQ_NOP, 32'h0000_0000, 32'h0000_0000, 5'd0);
    // build: insert into empty, append, insert in middle, insert at count, duplicate key
    send_request(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);
    send_request(REQ_APPEND, 32'hFFFF_FFFF, 32'h0000_0000, 5'd31);
    send_request(REQ_INSERT, 32'h1234_5678, 32'h9ABC_DEF0, 5'd1);
    send_request(REQ_INSERT, 32'h8000_0001, 32'h0000_0001, 5'd3);
    send_request(REQ_APPEND, 32'h1234_5678, 32'h0BAD_F00D, 5'd0);
    fill_level = 5;
    send_request(REQ_FINDK, 32'h1234_5678, 32'h0000_0000, 5'd0);
    send_request(REQ_FINDV, 32'h0000_0000, 32'h0BAD_F00D, 5'd0);
    send_request(REQ_FINDK, 32'h5555_AAAA, 32'h0000_0000, 5'd0);
    send_request(REQ_READ, 32'h0000_0000, 32'h0000_0000, 5'd4);
    send_request(REQ_READ, 32'h0000_0000, 32'h0000_0000, 5'd5);
    // duplicates: lowest index wins
    send_request(REQ_WRKEY, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0);
    send_request(REQ_FINDK, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0);
    send_request(REQ_WRVAL, 32'h0000_0000, 32'h0BAD_F00D, 5'd2);
    send_request(REQ_FINDV, 32'h0000_0000, 32'h0BAD_F00D, 5'd0);
    send_request(REQ_WRVAL, 32'h0000_0000, 32'h1111_1111, 5'd31);
    send_request(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
  endtask

  initial begin
    int unsigned roll;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    // fill the table with valid adds; there is no removal, so it stays full afterwards
    while (fill_level < DEPTH) begin
      if ($urandom_range(0, 1) == 0) begin
        send_request(REQ_APPEND, pick_key(), pick_value(), pick_pos());
      end else begin
        send_request(REQ_INSERT, pick_key(), pick_value(),
                     POS_W'($urandom_range(0, fill_level)));
      end
      fill_level++;
    end
    for (int n = 0; n < MIXED_ITEMS; n++) begin
      steady = (n >= 600 && n < 900);
      roll = $urandom_range(0, 99);
      if (roll < 18) begin
        send_request(REQ_FINDK, pick_key(), $urandom, pick_pos());
      end else if (roll < 34) begin
        send_request(REQ_FINDV, $urandom, pick_value(), pick_pos());
      end else if (roll < 48) begin
        send_request(REQ_READ, $urandom, $urandom, pick_pos());
      end else if (roll < 60) begin
        send_request(REQ_WRKEY, pick_key(), $urandom, pick_pos());
      end else if (roll < 72) begin
        send_request(REQ_WRVAL, $urandom, pick_value(), pick_pos());
      end else if (roll < 82) begin
        send_request(REQ_APPEND, pick_key(), pick_value(), pick_pos());
      end else if (roll < 95) begin
        send_request(REQ_INSERT, pick_key(), pick_value(), pick_pos());
      end else begin
        send_request(REQ_NOP, $urandom, $urandom, POS_W'($urandom_range(0, 31)));
      end
    end
    steady = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
